// File: src/fsbd_pkg.sv
// Shared types and constants for the flux stream block decoder.
// Used by fsbd_rsp_fifo and flux_stream_block_decoder; no dependencies.
package fsbd_pkg;

   // Block header codes.
   localparam logic [7:0] HDR_NOP1     = 8'h08;
   localparam logic [7:0] HDR_NOP2     = 8'h09;
   localparam logic [7:0] HDR_NOP3     = 8'h0A;
   localparam logic [7:0] HDR_OVERFLOW = 8'h0B;
   localparam logic [7:0] HDR_FLUX3    = 8'h0C;
   localparam logic [7:0] HDR_OOB      = 8'h0D;
   localparam logic [7:0] HDR_FLUX1    = 8'h0E;

   // Out-of-band block types.
   localparam logic [7:0] OOB_INFO   = 8'h01;
   localparam logic [7:0] OOB_INDEX  = 8'h02;
   localparam logic [7:0] OOB_END    = 8'h03;
   localparam logic [7:0] OOB_HWINFO = 8'h04;
   localparam logic [7:0] OOB_EOF    = 8'h0D;

   localparam logic [31:0] OVERFLOW_STEP = 32'h0001_0000;
   localparam logic [7:0]  MAX_INDEX     = 8'd128;
   localparam int          PAYLOAD_KEEP  = 12;

   // Result queue depth; the input side needs room for two results.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_FLUX2,
      PH_NOP,
      PH_FLUX3_A,
      PH_FLUX3_B,
      PH_OOB_TYPE,
      PH_SIZE_LO,
      PH_SIZE_HI,
      PH_PAYLOAD,
      PH_DISCARD
   } phase_type;

   typedef enum logic [1:0] {
      KIND_FLUX,
      KIND_INDEX,
      KIND_END
   } kind_type;

   typedef enum logic [3:0] {
      ST_OK,
      ST_MISSING_DATA,
      ST_BAD_CODE,
      ST_POSITION,
      ST_DEV_BUFFER,
      ST_DEV_INDEX,
      ST_TRANSFER,
      ST_BAD_OOB,
      ST_MISSING_END,
      ST_INDEX_PAST_END
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] flux_time;
      logic [31:0] position;
      logic [31:0] sample_count;
      logic [31:0] index_clock_count;
      status_type  status;
      logic [31:0] shortest_flux;
      logic [31:0] longest_flux;
      logic [31:0] transfer_bytes;
      logic [31:0] transfer_ticks;
      logic [31:0] transfer_blocks;
      logic [7:0]  index_total;
   } rsp_type;

   // Which of the two result slots carry an item this cycle.
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   function automatic status_type final_status(input logic [7:0]  dev,
                                               input logic        eof,
                                               input logic [31:0] offset,
                                               input logic [31:0] last_idx);
      status_type s;
      s = ST_OK;
      if (dev == 8'd1) begin
         s = ST_DEV_BUFFER;
      end else if (dev == 8'd2) begin
         s = ST_DEV_INDEX;
      end else if (dev != 8'd0) begin
         s = ST_TRANSFER;
      end else if (!eof) begin
         s = ST_MISSING_END;
      end else if (last_idx != 32'd0 && offset < last_idx) begin
         s = ST_INDEX_PAST_END;
      end
      return s;
   endfunction

endpackage

// File: src/fsbd_rsp_fifo.sv
// Small result queue that takes up to two items per cycle and gives one.
// Depends on fsbd_pkg.
module fsbd_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  fsbd_pkg::push_type push,
   input  fsbd_pkg::rsp_type  push_first,
   input  fsbd_pkg::rsp_type  push_second,
   output logic              room_for_two,
   output logic              out_valid,
   input  logic              out_ready,
   output fsbd_pkg::rsp_type  out_item
);

   fsbd_pkg::rsp_type                   mem_ff [fsbd_pkg::RSP_DEPTH];
   logic [fsbd_pkg::RSP_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [fsbd_pkg::RSP_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [fsbd_pkg::RSP_CNT_W-1:0]      count_ff, count_in;
   logic [fsbd_pkg::RSP_PTR_W-1:0]      wr_next;
   logic                                pop;

   assign out_valid    = (count_ff != '0);
   assign out_item     = mem_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= fsbd_pkg::RSP_CNT_W'(fsbd_pkg::RSP_DEPTH - 2));
   assign pop          = out_valid && out_ready;

   always_comb begin
      wr_next   = wr_ptr_ff + fsbd_pkg::RSP_PTR_W'(1);
      wr_ptr_in = wr_ptr_ff + fsbd_pkg::RSP_PTR_W'(push.first)
                            + fsbd_pkg::RSP_PTR_W'(push.second);
      rd_ptr_in = rd_ptr_ff + fsbd_pkg::RSP_PTR_W'(pop);
      count_in  = count_ff + fsbd_pkg::RSP_CNT_W'(push.first)
                           + fsbd_pkg::RSP_CNT_W'(push.second)
                           - fsbd_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The second item only ever comes together with the first.
   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ptr_ff] <= push_first;
      end
      if (push.second) begin
         mem_ff[wr_next] <= push_second;
      end
   end

endmodule

// File: src/flux_stream_block_decoder.sv
// Flux stream block decoder, top level.
// Depends on fsbd_pkg and fsbd_rsp_fifo.
//
//   Channel   Ports   Direction  Item
//   request   req_*   in         one stream byte and its last-byte flag
//   response  rsp_*   out        flux, index record or end result
//
// One byte is decoded per cycle while req_ready is high; its results enter a
// four-entry queue at the same clock edge and reach rsp_* behind any earlier
// results. A byte can give two results, which leave one per cycle while
// rsp_ready is high. req_ready is high whenever the queue has room for two
// items, so bytes flow every cycle while the output is taken. Reset is
// synchronous and returns the decoder to its header state with an empty queue.
module flux_stream_block_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_flux_time,
   output logic [31:0] rsp_position,
   output logic [31:0] rsp_sample_count,
   output logic [31:0] rsp_index_clock_count,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_shortest_flux,
   output logic [31:0] rsp_longest_flux,
   output logic [31:0] rsp_transfer_bytes,
   output logic [31:0] rsp_transfer_time,
   output logic [31:0] rsp_transfer_blocks,
   output logic [7:0]  rsp_index_total
);

   fsbd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  header_ff, header_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  oob_kind_ff, oob_kind_in;
   logic [7:0]  payload_ff [fsbd_pkg::PAYLOAD_KEEP];
   logic [7:0]  payload_in [fsbd_pkg::PAYLOAD_KEEP];
   logic [3:0]  fill_ff, fill_in;
   logic [7:0]  high_ff, high_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] prev_info_ff, prev_info_in;
   logic [7:0]  dev_status_ff, dev_status_in;
   logic [31:0] last_index_ff, last_index_in;
   logic [31:0] min_ff, min_in;
   logic [31:0] max_ff, max_in;
   logic [31:0] byte_sum_ff, byte_sum_in;
   logic [31:0] time_sum_ff, time_sum_in;
   logic [31:0] info_blocks_ff, info_blocks_in;
   logic [7:0]  indices_ff, indices_in;

   logic                  accept;
   logic                  room_for_two;
   logic [7:0]            b;
   logic                  flux_fire;
   logic [15:0]           flux_add;
   logic [1:0]            off_add;
   logic [31:0]           flux_val;
   logic                  finish;
   logic                  term;
   logic                  eof;
   logic                  idx_fire;
   logic                  clear;
   logic                  in_discard;
   logic [15:0]           bl_dec;
   logic [31:0]           sb;
   logic [31:0]           w0, w4, w8;
   fsbd_pkg::status_type  st;
   fsbd_pkg::push_type    push;
   fsbd_pkg::rsp_type     first_item, second_item, end_item, out_item;

   assign accept    = req_valid && req_ready;
   assign req_ready = room_for_two;
   assign b         = req_data_byte;

   always_comb begin
      phase_in       = phase_ff;
      header_in      = header_ff;
      bytes_left_in  = bytes_left_ff;
      oob_kind_in    = oob_kind_ff;
      payload_in     = payload_ff;
      fill_in        = fill_ff;
      high_in        = high_ff;
      acc_in         = acc_ff;
      offset_in      = offset_ff;
      prev_info_in   = prev_info_ff;
      dev_status_in  = dev_status_ff;
      last_index_in  = last_index_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      byte_sum_in    = byte_sum_ff;
      time_sum_in    = time_sum_ff;
      info_blocks_in = info_blocks_ff;
      indices_in     = indices_ff;

      flux_fire  = 1'b0;
      flux_add   = '0;
      off_add    = '0;
      flux_val   = '0;
      finish     = 1'b0;
      term       = 1'b0;
      eof        = 1'b0;
      idx_fire   = 1'b0;
      clear      = 1'b0;
      in_discard = 1'b0;
      sb         = '0;
      st         = fsbd_pkg::ST_OK;
      bl_dec     = (bytes_left_ff != 16'd0) ? bytes_left_ff - 16'd1 : 16'd0;

      if (accept) begin
         unique case (phase_ff)
            fsbd_pkg::PH_HEADER: begin
               header_in = b;
               priority if (b == fsbd_pkg::HDR_NOP1) begin
                  off_add = 2'd1;
               end else if (b == fsbd_pkg::HDR_OVERFLOW) begin
                  acc_in  = acc_ff + fsbd_pkg::OVERFLOW_STEP;
                  off_add = 2'd1;
               end else if (b == fsbd_pkg::HDR_NOP2) begin
                  bytes_left_in = 16'd1;
                  phase_in      = fsbd_pkg::PH_NOP;
               end else if (b == fsbd_pkg::HDR_NOP3) begin
                  bytes_left_in = 16'd2;
                  phase_in      = fsbd_pkg::PH_NOP;
               end else if (b == fsbd_pkg::HDR_FLUX3) begin
                  phase_in = fsbd_pkg::PH_FLUX3_A;
               end else if (b == fsbd_pkg::HDR_OOB) begin
                  phase_in = fsbd_pkg::PH_OOB_TYPE;
               end else if (b >= fsbd_pkg::HDR_FLUX1) begin
                  flux_fire = 1'b1;
                  flux_add  = {8'd0, b};
                  off_add   = 2'd1;
               end else begin
                  phase_in = fsbd_pkg::PH_FLUX2;
               end
            end
            fsbd_pkg::PH_FLUX2: begin
               flux_fire = 1'b1;
               flux_add  = {header_ff, b};
               off_add   = 2'd2;
               phase_in  = fsbd_pkg::PH_HEADER;
            end
            fsbd_pkg::PH_NOP: begin
               bytes_left_in = bl_dec;
               if (bl_dec == 16'd0) begin
                  off_add  = (header_ff == fsbd_pkg::HDR_NOP2) ? 2'd2 : 2'd3;
                  phase_in = fsbd_pkg::PH_HEADER;
               end
            end
            fsbd_pkg::PH_FLUX3_A: begin
               high_in  = b;
               phase_in = fsbd_pkg::PH_FLUX3_B;
            end
            fsbd_pkg::PH_FLUX3_B: begin
               flux_fire = 1'b1;
               flux_add  = {high_ff, b};
               off_add   = 2'd3;
               phase_in  = fsbd_pkg::PH_HEADER;
            end
            fsbd_pkg::PH_OOB_TYPE: begin
               oob_kind_in = b;
               phase_in    = fsbd_pkg::PH_SIZE_LO;
            end
            fsbd_pkg::PH_SIZE_LO: begin
               bytes_left_in = {8'd0, b};
               phase_in      = fsbd_pkg::PH_SIZE_HI;
            end
            fsbd_pkg::PH_SIZE_HI: begin
               if (oob_kind_ff == fsbd_pkg::OOB_EOF) begin
                  phase_in = fsbd_pkg::PH_HEADER;
                  term     = 1'b1;
                  eof      = 1'b1;
               end else begin
                  bytes_left_in = {b, bytes_left_ff[7:0]};
                  fill_in       = '0;
                  for (int i = 0; i < fsbd_pkg::PAYLOAD_KEEP; i++) begin
                     payload_in[i] = '0;
                  end
                  if ({b, bytes_left_ff[7:0]} == 16'd0) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = fsbd_pkg::PH_PAYLOAD;
                  end
               end
            end
            fsbd_pkg::PH_PAYLOAD: begin
               // Only the first twelve payload bytes are kept.
               if (fill_ff < 4'(fsbd_pkg::PAYLOAD_KEEP)) begin
                  for (int i = 0; i < fsbd_pkg::PAYLOAD_KEEP; i++) begin
                     if (fill_ff == 4'(i)) begin
                        payload_in[i] = b;
                     end
                  end
                  fill_in = fill_ff + 4'd1;
               end
               bytes_left_in = bl_dec;
               if (bl_dec == 16'd0) begin
                  finish = 1'b1;
               end
            end
            default: begin
               in_discard = 1'b1;
               if (req_last_byte) begin
                  clear = 1'b1;
               end
            end
         endcase
      end

      // A completed flux: add, track extremes, emit at the block start.
      if (flux_fire) begin
         flux_val = acc_ff + {16'd0, flux_add};
         if (flux_val < min_ff) begin
            min_in = flux_val;
         end
         if (flux_val > max_ff) begin
            max_in = flux_val;
         end
         acc_in = '0;
      end
      offset_in = offset_ff + {30'd0, off_add};

      w0 = {payload_in[3], payload_in[2], payload_in[1], payload_in[0]};
      w4 = {payload_in[7], payload_in[6], payload_in[5], payload_in[4]};
      w8 = {payload_in[11], payload_in[10], payload_in[9], payload_in[8]};

      if (finish) begin
         phase_in = fsbd_pkg::PH_HEADER;
         priority if (oob_kind_ff == fsbd_pkg::OOB_INFO) begin
            if (w0 != offset_ff) begin
               term = 1'b1;
               st   = fsbd_pkg::ST_POSITION;
            end else begin
               sb           = offset_ff - prev_info_ff;
               prev_info_in = offset_ff;
               if (sb != 32'd0) begin
                  byte_sum_in    = byte_sum_ff + sb;
                  time_sum_in    = time_sum_ff + w4;
                  info_blocks_in = info_blocks_ff + 32'd1;
               end
            end
         end else if (oob_kind_ff == fsbd_pkg::OOB_INDEX) begin
            if (indices_ff < fsbd_pkg::MAX_INDEX) begin
               indices_in    = indices_ff + 8'd1;
               last_index_in = w0;
               idx_fire      = 1'b1;
            end
         end else if (oob_kind_ff == fsbd_pkg::OOB_END) begin
            dev_status_in = payload_in[4];
            if (payload_in[4] == 8'd0 && w0 != offset_ff) begin
               term = 1'b1;
               st   = fsbd_pkg::ST_POSITION;
            end
         end else if (oob_kind_ff != fsbd_pkg::OOB_HWINFO) begin
            term = 1'b1;
            st   = fsbd_pkg::ST_BAD_OOB;
         end
      end

      if (accept && !in_discard) begin
         if (term) begin
            if (eof) begin
               st = fsbd_pkg::final_status(dev_status_in, 1'b1, offset_in, last_index_in);
            end
         end else if (req_last_byte) begin
            st   = (phase_in != fsbd_pkg::PH_HEADER) ? fsbd_pkg::ST_MISSING_DATA
                 : fsbd_pkg::final_status(dev_status_in, 1'b0, offset_in, last_index_in);
            term = 1'b1;
         end
      end

      // All results of one byte carry the running values after its update.
      first_item.kind              = idx_fire ? fsbd_pkg::KIND_INDEX : fsbd_pkg::KIND_FLUX;
      first_item.flux_time         = idx_fire ? 32'd0 : flux_val;
      first_item.position          = idx_fire ? w0 : offset_ff;
      first_item.sample_count      = idx_fire ? w4 : 32'd0;
      first_item.index_clock_count = idx_fire ? w8 : 32'd0;
      first_item.status            = fsbd_pkg::ST_OK;
      first_item.shortest_flux     = min_in;
      first_item.longest_flux      = max_in;
      first_item.transfer_bytes    = byte_sum_in;
      first_item.transfer_ticks    = time_sum_in;
      first_item.transfer_blocks   = info_blocks_in;
      first_item.index_total       = indices_in;

      end_item                   = first_item;
      end_item.kind              = fsbd_pkg::KIND_END;
      end_item.flux_time         = acc_in;
      end_item.position          = offset_in;
      end_item.sample_count      = '0;
      end_item.index_clock_count = '0;
      end_item.status            = st;

      if (term) begin
         if (req_last_byte) begin
            clear = 1'b1;
         end else begin
            phase_in = fsbd_pkg::PH_DISCARD;
         end
      end

      push.first  = flux_fire || idx_fire || term;
      push.second = (flux_fire || idx_fire) && term;
      second_item = end_item;
      if (!(flux_fire || idx_fire)) begin
         first_item = end_item;
      end

      if (clear) begin
         phase_in       = fsbd_pkg::PH_HEADER;
         header_in      = '0;
         bytes_left_in  = '0;
         oob_kind_in    = '0;
         for (int i = 0; i < fsbd_pkg::PAYLOAD_KEEP; i++) begin
            payload_in[i] = '0;
         end
         fill_in        = '0;
         high_in        = '0;
         acc_in         = '0;
         offset_in      = '0;
         prev_info_in   = '0;
         dev_status_in  = '0;
         last_index_in  = '0;
         min_in         = '1;
         max_in         = '0;
         byte_sum_in    = '0;
         time_sum_in    = '0;
         info_blocks_in = '0;
         indices_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= fsbd_pkg::PH_HEADER;
         header_ff      <= '0;
         bytes_left_ff  <= '0;
         oob_kind_ff    <= '0;
         for (int i = 0; i < fsbd_pkg::PAYLOAD_KEEP; i++) begin
            payload_ff[i] <= '0;
         end
         fill_ff        <= '0;
         high_ff        <= '0;
         acc_ff         <= '0;
         offset_ff      <= '0;
         prev_info_ff   <= '0;
         dev_status_ff  <= '0;
         last_index_ff  <= '0;
         min_ff         <= '1;
         max_ff         <= '0;
         byte_sum_ff    <= '0;
         time_sum_ff    <= '0;
         info_blocks_ff <= '0;
         indices_ff     <= '0;
      end else begin
         phase_ff       <= phase_in;
         header_ff      <= header_in;
         bytes_left_ff  <= bytes_left_in;
         oob_kind_ff    <= oob_kind_in;
         payload_ff     <= payload_in;
         fill_ff        <= fill_in;
         high_ff        <= high_in;
         acc_ff         <= acc_in;
         offset_ff      <= offset_in;
         prev_info_ff   <= prev_info_in;
         dev_status_ff  <= dev_status_in;
         last_index_ff  <= last_index_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         byte_sum_ff    <= byte_sum_in;
         time_sum_ff    <= time_sum_in;
         info_blocks_ff <= info_blocks_in;
         indices_ff     <= indices_in;
      end
   end

   fsbd_rsp_fifo u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_first   (first_item),
      .push_second  (second_item),
      .room_for_two (room_for_two),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_item     (out_item)
   );

   assign rsp_kind              = out_item.kind;
   assign rsp_flux_time         = out_item.flux_time;
   assign rsp_position          = out_item.position;
   assign rsp_sample_count      = out_item.sample_count;
   assign rsp_index_clock_count = out_item.index_clock_count;
   assign rsp_status            = out_item.status;
   assign rsp_shortest_flux     = out_item.shortest_flux;
   assign rsp_longest_flux      = out_item.longest_flux;
   assign rsp_transfer_bytes    = out_item.transfer_bytes;
   assign rsp_transfer_time     = out_item.transfer_ticks;
   assign rsp_transfer_blocks   = out_item.transfer_blocks;
   assign rsp_index_total       = out_item.index_total;

endmodule

// File: sim/flux_stream_block_decoder_test.sv
// Self-checking testbench for flux_stream_block_decoder: drives capture streams
// byte by byte and checks every result against a built-in decoder model.
// Depends on fsbd_pkg and the decoder RTL; needs nothing else.
`timescale 1ns / 100ps

module flux_stream_block_decoder_test;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stream_byte_type;

   typedef enum int {
      STYLE_CLEAN,
      STYLE_BROKEN,
      STYLE_NOISE
   } stream_style_type;

   // Any OOB type outside the decoded set ends the stream as a bad block.
   localparam logic [7:0] OOB_UNKNOWN = 8'h07;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_flux_time;
   logic [31:0] rsp_position;
   logic [31:0] rsp_sample_count;
   logic [31:0] rsp_index_clock_count;
   logic [3:0]  rsp_status;
   logic [31:0] rsp_shortest_flux;
   logic [31:0] rsp_longest_flux;
   logic [31:0] rsp_transfer_bytes;
   logic [31:0] rsp_transfer_time;
   logic [31:0] rsp_transfer_blocks;
   logic [7:0]  rsp_index_total;

   flux_stream_block_decoder u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .req_last_byte         (req_last_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_kind              (rsp_kind),
      .rsp_flux_time         (rsp_flux_time),
      .rsp_position          (rsp_position),
      .rsp_sample_count      (rsp_sample_count),
      .rsp_index_clock_count (rsp_index_clock_count),
      .rsp_status            (rsp_status),
      .rsp_shortest_flux     (rsp_shortest_flux),
      .rsp_longest_flux      (rsp_longest_flux),
      .rsp_transfer_bytes    (rsp_transfer_bytes),
      .rsp_transfer_time     (rsp_transfer_time),
      .rsp_transfer_blocks   (rsp_transfer_blocks),
      .rsp_index_total       (rsp_index_total)
   );

   always #5 clock = ~clock;

   // Stimulus and scoreboard storage.
   stream_byte_type   send_queue[$];
   logic [7:0]        stream_bytes[$];
   fsbd_pkg::rsp_type expected_results[$];
   stream_byte_type   drive_item;
   int                sender_idle = 0;
   int                receiver_idle = 0;
   int                bytes_queued = 0;
   int                bytes_sent = 0;
   int                captures = 0;
   int                results_checked = 0;
   int                mismatches = 0;
   int                kind_count[3] = '{0, 0, 0};
   logic [15:0]       status_seen = '0;

   // Decoder model state.
   fsbd_pkg::phase_type dec_phase;
   logic [7:0]  block_hdr;
   logic [16:0] remaining;
   logic [7:0]  oob_code;
   logic [7:0]  oob_payload[fsbd_pkg::PAYLOAD_KEEP];
   logic [3:0]  oob_fill;
   logic [7:0]  flux3_high;
   logic [31:0] pending_flux;
   logic [31:0] model_offset;
   logic [31:0] info_pos;
   logic [7:0]  device_code;
   logic [31:0] index_pos;
   logic [31:0] shortest;
   logic [31:0] longest;
   logic [31:0] info_byte_sum;
   logic [31:0] info_time_sum;
   logic [31:0] info_count;
   logic [7:0]  index_recs;

   function automatic void clear_decoder();
      dec_phase = fsbd_pkg::PH_HEADER;
      block_hdr = '0;
      remaining = '0;
      oob_code = '0;
      foreach (oob_payload[k]) oob_payload[k] = '0;
      oob_fill = '0;
      flux3_high = '0;
      pending_flux = '0;
      model_offset = '0;
      info_pos = '0;
      device_code = '0;
      index_pos = '0;
      shortest = '1;
      longest = '0;
      info_byte_sum = '0;
      info_time_sum = '0;
      info_count = '0;
      index_recs = '0;
   endfunction

   function automatic logic [31:0] payload_word(input int off);
      return {oob_payload[off + 3], oob_payload[off + 2], oob_payload[off + 1],
              oob_payload[off]};
   endfunction

   function automatic fsbd_pkg::rsp_type make_result(input fsbd_pkg::kind_type k,
                                                     input logic [31:0] ft,
                                                     input logic [31:0] pos,
                                                     input logic [31:0] sc,
                                                     input logic [31:0] icc,
                                                     input fsbd_pkg::status_type st);
      fsbd_pkg::rsp_type r;
      r.kind = k;
      r.flux_time = ft;
      r.position = pos;
      r.sample_count = sc;
      r.index_clock_count = icc;
      r.status = st;
      r.shortest_flux = shortest;
      r.longest_flux = longest;
      r.transfer_bytes = info_byte_sum;
      r.transfer_ticks = info_time_sum;
      r.transfer_blocks = info_count;
      r.index_total = index_recs;
      return r;
   endfunction

   function automatic fsbd_pkg::status_type stream_end_status(input logic saw_eof);
      if (device_code == 8'd1) return fsbd_pkg::ST_DEV_BUFFER;
      if (device_code == 8'd2) return fsbd_pkg::ST_DEV_INDEX;
      if (device_code != 8'd0) return fsbd_pkg::ST_TRANSFER;
      if (!saw_eof) return fsbd_pkg::ST_MISSING_END;
      if (index_pos != 0 && model_offset < index_pos) return fsbd_pkg::ST_INDEX_PAST_END;
      return fsbd_pkg::ST_OK;
   endfunction

   function automatic void emit_flux(input logic [31:0] add, input logic [31:0] len);
      pending_flux += add;
      if (pending_flux < shortest) shortest = pending_flux;
      if (pending_flux > longest) longest = pending_flux;
      expected_results.push_back(make_result(fsbd_pkg::KIND_FLUX, pending_flux,
                                             model_offset, 0, 0, fsbd_pkg::ST_OK));
      pending_flux = '0;
      model_offset += len;
   endfunction

   // Advances the model by one stream byte and queues the results it causes.
   function automatic void decode_byte(input logic [7:0] b, input logic last);
      logic                 term;
      logic                 eof;
      logic                 finish;
      fsbd_pkg::status_type st;
      logic [31:0]          span;
      term = 1'b0;
      eof = 1'b0;
      finish = 1'b0;
      st = fsbd_pkg::ST_OK;
      if (dec_phase == fsbd_pkg::PH_DISCARD) begin
         if (last) clear_decoder();
         return;
      end
      case (dec_phase)
         fsbd_pkg::PH_HEADER: begin
            block_hdr = b;
            if (b == fsbd_pkg::HDR_NOP1) begin
               model_offset += 1;
            end else if (b == fsbd_pkg::HDR_OVERFLOW) begin
               pending_flux += fsbd_pkg::OVERFLOW_STEP;
               model_offset += 1;
            end else if (b == fsbd_pkg::HDR_NOP2) begin
               remaining = 1;
               dec_phase = fsbd_pkg::PH_NOP;
            end else if (b == fsbd_pkg::HDR_NOP3) begin
               remaining = 2;
               dec_phase = fsbd_pkg::PH_NOP;
            end else if (b == fsbd_pkg::HDR_FLUX3) begin
               dec_phase = fsbd_pkg::PH_FLUX3_A;
            end else if (b == fsbd_pkg::HDR_OOB) begin
               dec_phase = fsbd_pkg::PH_OOB_TYPE;
            end else if (b >= fsbd_pkg::HDR_FLUX1) begin
               emit_flux(32'(b), 1);
            end else begin
               dec_phase = fsbd_pkg::PH_FLUX2;
            end
         end
         fsbd_pkg::PH_FLUX2: begin
            emit_flux(32'({block_hdr, b}), 2);
            dec_phase = fsbd_pkg::PH_HEADER;
         end
         fsbd_pkg::PH_NOP: begin
            if (remaining != 0) remaining -= 1;
            if (remaining == 0) begin
               model_offset += (block_hdr == fsbd_pkg::HDR_NOP2) ? 2 : 3;
               dec_phase = fsbd_pkg::PH_HEADER;
            end
         end
         fsbd_pkg::PH_FLUX3_A: begin
            flux3_high = b;
            dec_phase = fsbd_pkg::PH_FLUX3_B;
         end
         fsbd_pkg::PH_FLUX3_B: begin
            emit_flux(32'({flux3_high, b}), 3);
            dec_phase = fsbd_pkg::PH_HEADER;
         end
         fsbd_pkg::PH_OOB_TYPE: begin
            oob_code = b;
            dec_phase = fsbd_pkg::PH_SIZE_LO;
         end
         fsbd_pkg::PH_SIZE_LO: begin
            remaining = 17'(b);
            dec_phase = fsbd_pkg::PH_SIZE_HI;
         end
         fsbd_pkg::PH_SIZE_HI: begin
            if (oob_code == fsbd_pkg::OOB_EOF) begin
               dec_phase = fsbd_pkg::PH_HEADER;
               term = 1'b1;
               eof = 1'b1;
            end else begin
               remaining = 17'({b, remaining[7:0]});
               oob_fill = '0;
               foreach (oob_payload[k]) oob_payload[k] = '0;
               if (remaining == 0) finish = 1'b1;
               else dec_phase = fsbd_pkg::PH_PAYLOAD;
            end
         end
         fsbd_pkg::PH_PAYLOAD: begin
            if (oob_fill < fsbd_pkg::PAYLOAD_KEEP) begin
               oob_payload[oob_fill] = b;
               oob_fill += 1;
            end
            if (remaining != 0) remaining -= 1;
            if (remaining == 0) finish = 1'b1;
         end
         default: ;
      endcase

      if (finish) begin
         dec_phase = fsbd_pkg::PH_HEADER;
         if (oob_code == fsbd_pkg::OOB_INFO) begin
            if (payload_word(0) != model_offset) begin
               term = 1'b1;
               st = fsbd_pkg::ST_POSITION;
            end else begin
               span = model_offset - info_pos;
               info_pos = model_offset;
               if (span != 0) begin
                  info_byte_sum += span;
                  info_time_sum += payload_word(4);
                  info_count += 1;
               end
            end
         end else if (oob_code == fsbd_pkg::OOB_INDEX) begin
            if (index_recs < fsbd_pkg::MAX_INDEX) begin
               index_recs += 1;
               index_pos = payload_word(0);
               expected_results.push_back(make_result(fsbd_pkg::KIND_INDEX, 0,
                                                      payload_word(0), payload_word(4),
                                                      payload_word(8), fsbd_pkg::ST_OK));
            end
         end else if (oob_code == fsbd_pkg::OOB_END) begin
            device_code = oob_payload[4];
            if (device_code == 0 && payload_word(0) != model_offset) begin
               term = 1'b1;
               st = fsbd_pkg::ST_POSITION;
            end
         end else if (oob_code != fsbd_pkg::OOB_HWINFO) begin
            term = 1'b1;
            st = fsbd_pkg::ST_BAD_OOB;
         end
      end

      if (term) begin
         if (eof) st = stream_end_status(1'b1);
      end else if (last) begin
         st = (dec_phase != fsbd_pkg::PH_HEADER) ? fsbd_pkg::ST_MISSING_DATA
                                                 : stream_end_status(1'b0);
         term = 1'b1;
      end
      if (term) begin
         status_seen[st] = 1'b1;
         expected_results.push_back(make_result(fsbd_pkg::KIND_END, pending_flux,
                                                model_offset, 0, 0, st));
         if (last) clear_decoder();
         else dec_phase = fsbd_pkg::PH_DISCARD;
      end
   endfunction

   // Moves the bytes built so far into the send queue; the final one ends the capture.
   function automatic void queue_stream();
      stream_byte_type item;
      foreach (stream_bytes[k]) begin
         item.data = stream_bytes[k];
         item.last = (k == stream_bytes.size() - 1);
         send_queue.push_back(item);
      end
      bytes_queued += stream_bytes.size();
      captures += 1;
      stream_bytes.delete();
   endfunction

   // Appends an OOB block; the first twelve payload bytes come from the three words.
   function automatic void add_oob(input logic [7:0] code, input int sz,
                                   input logic [31:0] w0, input logic [31:0] w1,
                                   input logic [31:0] w2);
      logic [95:0] words;
      words = {w2, w1, w0};
      stream_bytes.push_back(fsbd_pkg::HDR_OOB);
      stream_bytes.push_back(code);
      stream_bytes.push_back(8'(sz));
      stream_bytes.push_back(8'(sz >> 8));
      for (int k = 0; k < sz; k++) begin
         if (k < fsbd_pkg::PAYLOAD_KEEP) stream_bytes.push_back(words[8 * k +: 8]);
         else stream_bytes.push_back(8'($urandom_range(255)));
      end
   endfunction

   // Builds one capture. Clean ones are well formed, with EOF and up to three bytes last;
   // broken ones carry bad positions, unknown OOB types, no EOF or a cut; noise is raw.
   function automatic void add_stream(input int blocks, input stream_style_type style);
      logic [31:0] pos;
      logic [31:0] w0;
      logic [31:0] dev;
      int          pick;
      int          sz;
      int          cut;
      pos = '0;
      if (style == STYLE_NOISE) begin
         repeat (blocks * 3) stream_bytes.push_back(8'($urandom_range(255)));
      end else begin
         repeat (blocks) begin
            pick = $urandom_range(99);
            if (pick < 40 || (pick >= 97 && style == STYLE_CLEAN)) begin
               stream_bytes.push_back(8'($urandom_range(255, 14)));
               pos += 1;
            end else if (pick < 54) begin
               stream_bytes.push_back(8'($urandom_range(7)));
               stream_bytes.push_back(8'($urandom_range(255)));
               pos += 2;
            end else if (pick < 61) begin
               stream_bytes.push_back(fsbd_pkg::HDR_FLUX3);
               stream_bytes.push_back(8'($urandom_range(255)));
               stream_bytes.push_back(8'($urandom_range(255)));
               pos += 3;
            end else if (pick < 67) begin
               sz = $urandom_range(3, 1);
               stream_bytes.push_back(8'(fsbd_pkg::HDR_NOP1 + sz - 1));
               repeat (sz - 1) stream_bytes.push_back(8'($urandom_range(255)));
               pos += sz;
            end else if (pick < 72) begin
               stream_bytes.push_back(fsbd_pkg::HDR_OVERFLOW);
               pos += 1;
            end else if (pick < 81) begin
               case ($urandom_range(3))
                  0: sz = 4;
                  3: sz = $urandom_range(24, 13);
                  default: sz = 8;
               endcase
               w0 = pos;
               if (style == STYLE_BROKEN && $urandom_range(5) == 0) begin
                  w0 = pos + $urandom_range(3, 1);
               end
               add_oob(fsbd_pkg::OOB_INFO, sz, w0, $urandom, $urandom);
            end else if (pick < 88) begin
               case ($urandom_range(4))
                  3: sz = $urandom_range(11, 1);
                  4: sz = $urandom_range(20, 13);
                  default: sz = 12;
               endcase
               case ($urandom_range(3))
                  2: w0 = pos + $urandom_range(300, 1);
                  3: w0 = $urandom;
                  default: w0 = pos;
               endcase
               add_oob(fsbd_pkg::OOB_INDEX, sz, w0, $urandom, $urandom);
            end else if (pick < 91) begin
               add_oob(fsbd_pkg::OOB_HWINFO, $urandom_range(20), $urandom, $urandom,
                       $urandom);
            end else if (pick < 97) begin
               dev = ($urandom_range(9) < 7) ? 0 : $urandom_range(4, 1);
               w0 = pos;
               if (style == STYLE_BROKEN && $urandom_range(3) == 0) w0 = pos - 1;
               add_oob(fsbd_pkg::OOB_END, 8, w0, ($urandom & 32'hFFFF_FF00) | dev,
                       $urandom);
            end else begin
               pick = $urandom_range(255, 5);
               add_oob((pick == fsbd_pkg::OOB_EOF) ? 8'h00 : 8'(pick), $urandom_range(6),
                       $urandom, $urandom, $urandom);
            end
         end
         if (style == STYLE_CLEAN || $urandom_range(2) == 0) begin
            stream_bytes.push_back(fsbd_pkg::HDR_OOB);
            stream_bytes.push_back(fsbd_pkg::OOB_EOF);
            stream_bytes.push_back(8'($urandom_range(255)));
            stream_bytes.push_back(8'($urandom_range(255)));
            if (style == STYLE_CLEAN) begin
               repeat ($urandom_range(3)) stream_bytes.push_back(8'($urandom_range(255)));
            end
         end else if ($urandom_range(1) == 0) begin
            cut = $urandom_range(stream_bytes.size(), 1);
            while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
         end
      end
      queue_stream();
   endfunction

   // Byte driver: the model is advanced on each accepted byte.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data_byte <= 8'h00;
         req_last_byte <= 1'b0;
         clear_decoder();
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_data_byte, req_last_byte);
            bytes_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_queue.size() != 0 && $urandom_range(99) >= sender_idle) begin
               drive_item = send_queue.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= drive_item.data;
               req_last_byte <= drive_item.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   fsbd_pkg::rsp_type got;
   fsbd_pkg::rsp_type want;
   logic [31:0] got_f[12];
   logic [31:0] want_f[12];
   string       field_names[12] = '{"kind", "flux_time", "position", "sample_count",
                                    "index_clock_count", "status", "shortest_flux",
                                    "longest_flux", "transfer_bytes", "transfer_ticks",
                                    "transfer_blocks", "index_total"};

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle);
         if (rsp_valid && rsp_ready) begin
            got.kind = fsbd_pkg::kind_type'(rsp_kind);
            got.flux_time = rsp_flux_time;
            got.position = rsp_position;
            got.sample_count = rsp_sample_count;
            got.index_clock_count = rsp_index_clock_count;
            got.status = fsbd_pkg::status_type'(rsp_status);
            got.shortest_flux = rsp_shortest_flux;
            got.longest_flux = rsp_longest_flux;
            got.transfer_bytes = rsp_transfer_bytes;
            got.transfer_ticks = rsp_transfer_time;
            got.transfer_blocks = rsp_transfer_blocks;
            got.index_total = rsp_index_total;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%t: unexpected result, kind %0d position %0h", $realtime,
                           rsp_kind, rsp_position);
               end
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (want.kind <= fsbd_pkg::KIND_END) kind_count[want.kind]++;
               got_f = '{32'(got.kind), got.flux_time, got.position, got.sample_count,
                         got.index_clock_count, 32'(got.status), got.shortest_flux,
                         got.longest_flux, got.transfer_bytes, got.transfer_ticks,
                         got.transfer_blocks, 32'(got.index_total)};
               want_f = '{32'(want.kind), want.flux_time, want.position, want.sample_count,
                          want.index_clock_count, 32'(want.status), want.shortest_flux,
                          want.longest_flux, want.transfer_bytes, want.transfer_ticks,
                          want.transfer_blocks, 32'(want.index_total)};
               if (got_f != want_f) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%t: result %0d differs", $realtime, results_checked);
                     for (int f = 0; f < 12; f++) begin
                        if (got_f[f] !== want_f[f]) begin
                           $display("   %s expected %0h actual %0h", field_names[f],
                                    want_f[f], got_f[f]);
                        end
                     end
                  end
               end
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin
               sender_idle = 25;
               receiver_idle = 86;
            end
            1: begin
               sender_idle = 86;
               receiver_idle = 25;
            end
            default: begin
               sender_idle = 0;
               receiver_idle = 0;
            end
         endcase
         if (stage == 0) begin
            // Every header kind, both byte extremes, an overflow ahead of a
            // three-byte flux, an empty hardware block and EOF on the last byte.
            stream_bytes = '{8'h00, 8'h00, 8'hFF, fsbd_pkg::HDR_FLUX1, 8'h07, 8'hFF,
                             fsbd_pkg::HDR_NOP1, fsbd_pkg::HDR_NOP2, 8'h55,
                             fsbd_pkg::HDR_NOP3, 8'h00, 8'hFF, fsbd_pkg::HDR_OVERFLOW,
                             fsbd_pkg::HDR_FLUX3, 8'hFF, 8'hFF, fsbd_pkg::HDR_OOB,
                             fsbd_pkg::OOB_HWINFO, 8'h00, 8'h00, fsbd_pkg::HDR_OOB,
                             fsbd_pkg::OOB_EOF, 8'h00, 8'h00};
            queue_stream();
            // Unknown OOB type; the trailing byte is discarded.
            stream_bytes = '{fsbd_pkg::HDR_OOB, OOB_UNKNOWN, 8'h00, 8'h00, 8'h42};
            queue_stream();
         end
         while (bytes_queued < 130 * (stage + 1)) begin
            case ($urandom_range(9))
               0: add_stream($urandom_range(30, 2), STYLE_NOISE);
               1, 2: add_stream($urandom_range(30, 2), STYLE_BROKEN);
               default: add_stream($urandom_range(30, 2), STYLE_CLEAN);
            endcase
         end
         while (send_queue.size() != 0) @(posedge clock);
      end
      while (req_valid || expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_results.size() != 0) begin
         mismatches += expected_results.size();
         $display("%0d expected results never arrived", expected_results.size());
      end
      $display("Sent %0d bytes in %0d captures; checked %0d results", bytes_sent, captures,
               results_checked);
      $display("Flux %0d, index %0d, end %0d; end statuses reached (bit per code) %b",
               kind_count[0], kind_count[1], kind_count[2], status_seen[9:0]);
      if (mismatches == 0) begin
         $display("flux_stream_block_decoder_test passed");
      end else begin
         $display("flux_stream_block_decoder_test failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d bytes unsent and %0d results outstanding",
               send_queue.size(), expected_results.size());
      $display("flux_stream_block_decoder_test failed");
      $finish;
   end

endmodule
